// ===== rtl/four_register_byte_cpu_execute_core_defines.svh =====
// Assertion macros shared by the RTL of the byte CPU execute core.
`ifndef FOUR_REGISTER_BYTE_CPU_EXECUTE_CORE_DEFINES_SVH
`define FOUR_REGISTER_BYTE_CPU_EXECUTE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising clock edge while out of reset.
`define FRBCE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds whenever its antecedent is seen.
`define FRBCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define FRBCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FRBCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define FRBCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define FRBCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/frbce_pkg.sv =====
package frbce_pkg;

  // Result status codes.
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_OUT     = 3'd1;
  localparam logic [2:0] ST_BADOP   = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_HALTED  = 3'd4;

  // Lower bounds of the opcode groups.
  localparam logic [7:0] OP_ADD = 8'h80;
  localparam logic [7:0] OP_SUB = 8'h90;
  localparam logic [7:0] OP_MUL = 8'hA0;
  localparam logic [7:0] OP_DIV = 8'hB0;
  localparam logic [7:0] OP_IN  = 8'hC0;
  localparam logic [7:0] OP_OUT = 8'hC4;
  localparam logic [7:0] OP_BAD = 8'hC8;

  // Register that receives the immediate load.
  localparam logic [1:0] IMM_REG = 2'd3;

  // Number of shift-add or shift-subtract steps of a multiply or divide.
  localparam int unsigned STEPS = 8;

endpackage

// ===== rtl/four_register_byte_cpu_execute_core.sv =====
// Byte CPU execute core: four 8-bit registers, one instruction per item.
// Input channel (in_valid_i/in_ready_o) carries an instruction byte and an
// input byte; output channel (out_valid_o/out_ready_i) returns one result
// item per instruction: a status code and, for OUT, the register value.
// An item is taken only while the sequencer is idle. Add and subtract use
// the shared 9-bit adder for one step; multiply (shift-add) and unsigned
// divide (restoring, shift-subtract) use it for eight steps under a 3-bit
// step counter. The sequencer goes from idle to the step state for add,
// subtract, multiply and divide, then to the finish state; loads, OUT and
// errors go from idle straight to finish. The sequencer returns to idle as
// the result is loaded into the output register, so a new item is taken
// only after the last one is through.
// Reset clears the four registers to zero and leaves the core running.
// An invalid opcode or a divide by zero halts the core until reset;
// every later item answers the halted status without changing state.
// When the receiver stalls, the result waits in the output register and
// a finished next item waits in the sequencer until the register frees.
`include "four_register_byte_cpu_execute_core_defines.svh"

module four_register_byte_cpu_execute_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] instruction_i,
  input  logic [7:0] in_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] out_value_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    K_LDI,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_IN,
    K_OUT,
    K_BAD,
    K_DIVZ,
    K_HALT
  } kind_e;

  state_e     state_q;
  kind_e      kind_q;
  kind_e      kind_d;
  logic [7:0] regs_q [4];
  logic       halted_q;
  logic       out_valid_q;
  logic [2:0] status_q;
  logic [2:0] status_d;
  logic [7:0] out_value_q;
  logic [7:0] out_value_d;
  logic [2:0] cnt_q;

  // Datapath registers of the item being worked on.
  logic [7:0] op_q;
  logic [7:0] in_q;
  logic [7:0] a_q;
  logic [7:0] a_d;
  logic [7:0] b_q;
  logic [7:0] b_d;
  logic [7:0] acc_q;
  logic [7:0] acc_d;
  logic [7:0] rem_q;
  logic [7:0] rem_d;

  logic [1:0] dst;
  logic [1:0] src;
  logic       accept;
  logic       out_free;
  logic       finish;
  logic       last_step;

  // Shared adder.
  logic [8:0] add_x;
  logic [8:0] add_y;
  logic       add_sub;
  logic [9:0] add_sum;
  logic       qbit;

  assign dst       = instruction_i[3:2];
  assign src       = instruction_i[1:0];
  assign in_ready_o = (state_q == S_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign finish    = (state_q == S_FINISH) && out_free;
  assign last_step = (cnt_q == 3'(frbce_pkg::STEPS - 1));

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_value_o = out_value_q;

  always_comb begin
    priority if (halted_q) begin
      kind_d = K_HALT;
    end else if (instruction_i >= frbce_pkg::OP_BAD) begin
      kind_d = K_BAD;
    end else if (instruction_i >= frbce_pkg::OP_OUT) begin
      kind_d = K_OUT;
    end else if (instruction_i >= frbce_pkg::OP_IN) begin
      kind_d = K_IN;
    end else if (instruction_i >= frbce_pkg::OP_DIV) begin
      kind_d = (regs_q[src] == 8'd0) ? K_DIVZ : K_DIV;
    end else if (instruction_i >= frbce_pkg::OP_MUL) begin
      kind_d = K_MUL;
    end else if (instruction_i >= frbce_pkg::OP_SUB) begin
      kind_d = K_SUB;
    end else if (instruction_i >= frbce_pkg::OP_ADD) begin
      kind_d = K_ADD;
    end else begin
      kind_d = K_LDI;
    end
  end

  // Operand selection for the shared adder. A subtract adds the inverted
  // operand plus one, so the top sum bit is set when no borrow occurs.
  always_comb begin
    add_x   = {1'b0, a_q};
    add_y   = {1'b0, b_q};
    add_sub = 1'b0;
    unique case (kind_q)
      K_SUB: begin
        add_sub = 1'b1;
      end
      K_MUL: begin
        add_x = {1'b0, acc_q};
        add_y = b_q[0] ? {1'b0, a_q} : 9'd0;
      end
      K_DIV: begin
        add_x   = {rem_q, a_q[7]};
        add_y   = {1'b0, b_q};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    add_sum = {1'b0, add_x} + {1'b0, add_y ^ {9{add_sub}}} + 10'(add_sub);
  end

  assign qbit = add_sum[9];

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    acc_d = acc_q;
    rem_d = rem_q;
    unique case (kind_q)
      K_ADD, K_SUB: begin
        acc_d = add_sum[7:0];
      end
      K_MUL: begin
        acc_d = add_sum[7:0];
        a_d   = {a_q[6:0], 1'b0};
        b_d   = {1'b0, b_q[7:1]};
      end
      K_DIV: begin
        // The remainder stays below the divisor, so it fits in 8 bits.
        rem_d = qbit ? add_sum[7:0] : add_x[7:0];
        a_d   = {a_q[6:0], qbit};
      end
      default: begin
      end
    endcase
  end

  // Status and value of the result item for the finished instruction.
  always_comb begin
    status_d    = frbce_pkg::ST_DONE;
    out_value_d = 8'd0;
    unique case (kind_q)
      K_OUT: begin
        status_d    = frbce_pkg::ST_OUT;
        out_value_d = b_q;
      end
      K_BAD: status_d = frbce_pkg::ST_BADOP;
      K_DIVZ: status_d = frbce_pkg::ST_DIVZERO;
      K_HALT: status_d = frbce_pkg::ST_HALTED;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= instruction_i;
      in_q   <= in_value_i;
      a_q    <= regs_q[dst];
      b_q    <= regs_q[src];
      acc_q  <= 8'd0;
      rem_q  <= 8'd0;
      kind_q <= kind_d;
    end else if (state_q == S_CALC) begin
      a_q   <= a_d;
      b_q   <= b_d;
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      regs_q      <= '{default: 8'd0};
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= frbce_pkg::ST_DONE;
      out_value_q <= 8'd0;
      cnt_q       <= 3'd0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= 3'd0;
          if (accept) begin
            if (kind_d == K_ADD || kind_d == K_SUB || kind_d == K_MUL ||
                kind_d == K_DIV) begin
              state_q <= S_CALC;
            end else begin
              state_q <= S_FINISH;
            end
          end
        end
        S_CALC: begin
          cnt_q <= cnt_q + 3'd1;
          if (kind_q == K_ADD || kind_q == K_SUB || last_step) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            status_q    <= status_d;
            out_value_q <= out_value_d;
            unique case (kind_q)
              K_LDI: regs_q[frbce_pkg::IMM_REG] <= op_q;
              K_ADD, K_SUB, K_MUL: regs_q[op_q[3:2]] <= acc_q;
              K_DIV: regs_q[op_q[3:2]] <= a_q;
              K_IN: regs_q[op_q[1:0]] <= in_q;
              K_BAD, K_DIVZ: halted_q <= 1'b1;
              default: begin
              end
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `FRBCE_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halted_q, halted_q,
                     "halted state cleared without reset")
  `FRBCE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !in_ready_o,
                     "core ready again right after accepting an item")
  `FRBCE_ASSERT_IMPL(a_value_only_on_out, clk_i, rst_ni,
                     out_valid_o && (status_o != frbce_pkg::ST_OUT),
                     out_value_o == 8'd0,
                     "nonzero output value on a result that is not OUT")
  `FRBCE_ASSERT_IMPL(a_halted_status, clk_i, rst_ni,
                     accept && halted_q, kind_d == K_HALT,
                     "item accepted while halted not marked as ignored")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] instruction_i;
  logic [7:0] in_value_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] status_o;
  logic [7:0] out_value_o;

  four_register_byte_cpu_execute_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .instruction_i(instruction_i),
    .in_value_i   (in_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .out_value_o  (out_value_o)
  );

  // Mirrors the register file and halt flag, and queues the status and value that
  // each accepted instruction should produce.
  class cpu_scoreboard;
    logic [7:0]  regs [4];
    bit          halted;
    logic [2:0]  status_q [$];
    logic [7:0]  value_q [$];
    int unsigned mismatches;

    function new();
      foreach (regs[k]) regs[k] = 8'h00;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    function void note_item(logic [7:0] instr, logic [7:0] inval);
      logic [1:0] dst;
      logic [1:0] src;
      logic [7:0] a;
      logic [7:0] b;
      logic [2:0] st;
      logic [7:0] ov;
      dst = instr[3:2];
      src = instr[1:0];
      a   = regs[dst];
      b   = regs[src];
      st  = frbce_pkg::ST_DONE;
      ov  = 8'h00;
      if (halted) begin
        st = frbce_pkg::ST_HALTED;
      end else if (instr >= frbce_pkg::OP_BAD) begin
        st     = frbce_pkg::ST_BADOP;
        halted = 1'b1;
      end else if (instr < frbce_pkg::OP_ADD) begin
        regs[frbce_pkg::IMM_REG] = instr;
      end else if (instr < frbce_pkg::OP_SUB) begin
        regs[dst] = a + b;
      end else if (instr < frbce_pkg::OP_MUL) begin
        regs[dst] = a - b;
      end else if (instr < frbce_pkg::OP_DIV) begin
        regs[dst] = a * b;
      end else if (instr < frbce_pkg::OP_IN) begin
        if (b == 8'h00) begin
          st     = frbce_pkg::ST_DIVZERO;
          halted = 1'b1;
        end else begin
          regs[dst] = a / b;
        end
      end else if (instr < frbce_pkg::OP_OUT) begin
        regs[src] = inval;
      end else begin
        st = frbce_pkg::ST_OUT;
        ov = b;
      end
      status_q.push_back(st);
      value_q.push_back(ov);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] val);
      logic [2:0] want_st;
      logic [7:0] want_val;
      if (status_q.size() == 0) begin
        flag($sformatf("result with nothing outstanding: status %0d value %02h", st, val));
        return;
      end
      want_st  = status_q.pop_front();
      want_val = value_q.pop_front();
      if (st !== want_st)
        flag($sformatf("status: expected %0d, got %0d", want_st, st));
      if (val !== want_val)
        flag($sformatf("out_value: expected %02h, got %02h", want_val, val));
    endfunction
  endclass

  cpu_scoreboard sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("four_register_byte_cpu_execute_core: mismatch");
    $finish;
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_item(instruction_i, in_value_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(status_o, out_value_o);
  end

  function automatic logic [7:0] encode(logic [7:0] base, logic [1:0] dst, logic [1:0] src);
    return base | {4'd0, dst, src};
  endfunction

  // Draws a legal opcode. A divide whose divisor register holds zero is turned
  // into an input load of that register so the core keeps running.
  function automatic logic [7:0] pick_opcode();
    int unsigned kind;
    logic [7:0]  op;
    kind = $urandom_range(0, 99);
    if (kind < 15)      op = 8'($urandom_range(0, 127));
    else if (kind < 55) op = frbce_pkg::OP_ADD + 8'($urandom_range(0, 47));
    else if (kind < 70) op = frbce_pkg::OP_DIV | 8'($urandom_range(0, 15));
    else if (kind < 85) op = frbce_pkg::OP_IN | 8'($urandom_range(0, 3));
    else                op = frbce_pkg::OP_OUT | 8'($urandom_range(0, 3));
    if (op >= frbce_pkg::OP_DIV && op < frbce_pkg::OP_IN && sb.regs[op[1:0]] == 8'h00)
      op = encode(frbce_pkg::OP_IN, 2'd0, op[1:0]);
    return op;
  endfunction

  // Called and returns at a falling edge; leaves valid high after acceptance.
  task automatic send_item(input logic [7:0] instr, input logic [7:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    instruction_i <= instr;
    in_value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  int unsigned send_pct [4] = '{0, 50, 0, 34};
  int unsigned recv_pct [4] = '{0, 0, 50, 34};

  initial begin
    logic [1:0] k;
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    instruction_i  = 8'h00;
    in_value_i     = 8'h00;
    out_ready_i    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Wraparound of add, subtract and multiply, same register as source and
    // destination, immediate extremes, and every output register.
    send_item(encode(frbce_pkg::OP_IN, 2'd0, 2'd0), 8'hFF);
    send_item(encode(frbce_pkg::OP_IN, 2'd0, 2'd1), 8'h01);
    send_item(encode(frbce_pkg::OP_IN, 2'd0, 2'd2), 8'h80);
    send_item(8'h00, 8'hA5);
    send_item(8'h7F, 8'h00);
    send_item(encode(frbce_pkg::OP_ADD, 2'd0, 2'd1), 8'h3C);
    send_item(encode(frbce_pkg::OP_SUB, 2'd0, 2'd1), 8'h00);
    send_item(encode(frbce_pkg::OP_MUL, 2'd2, 2'd2), 8'hFF);
    send_item(encode(frbce_pkg::OP_IN, 2'd0, 2'd2), 8'hC8);
    send_item(encode(frbce_pkg::OP_DIV, 2'd2, 2'd2), 8'h00);
    send_item(encode(frbce_pkg::OP_DIV, 2'd0, 2'd3), 8'h5A);
    send_item(encode(frbce_pkg::OP_SUB, 2'd3, 2'd3), 8'h00);
    send_item(encode(frbce_pkg::OP_ADD, 2'd3, 2'd2), 8'h00);
    send_item(encode(frbce_pkg::OP_MUL, 2'd1, 2'd3), 8'h00);
    send_item(8'h55, 8'hFF);
    send_item(encode(frbce_pkg::OP_OUT, 2'd0, 2'd0), 8'hFF);
    send_item(encode(frbce_pkg::OP_OUT, 2'd0, 2'd1), 8'h00);
    send_item(encode(frbce_pkg::OP_OUT, 2'd0, 2'd2), 8'hFF);
    send_item(encode(frbce_pkg::OP_OUT, 2'd0, 2'd3), 8'h00);
    send_item(encode(frbce_pkg::OP_DIV, 2'd1, 2'd0), 8'h00);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      repeat (400) send_item(pick_opcode(), 8'($urandom));
      drain();
    end

    // Only one halt can happen per run, so the seed picks its cause.
    k = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 1) begin
      send_item(8'($urandom_range(32'(frbce_pkg::OP_BAD), 255)), 8'($urandom));
    end else begin
      send_item(encode(frbce_pkg::OP_IN, 2'd0, k), 8'h00);
      send_item(encode(frbce_pkg::OP_DIV, 2'($urandom_range(0, 3)), k), 8'($urandom));
    end
    send_item(8'hFF, 8'($urandom));
    send_item(encode(frbce_pkg::OP_IN, 2'd0, k), 8'($urandom));
    send_item(encode(frbce_pkg::OP_OUT, 2'd0, k), 8'($urandom));
    repeat (24) send_item(8'($urandom), 8'($urandom));
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("four_register_byte_cpu_execute_core: match");
    end else begin
      $display("four_register_byte_cpu_execute_core: mismatch");
    end
    $finish;
  end

endmodule
